// ----- rtl/mast_pkg.sv -----
package mast_pkg;
    localparam int MAX_WINDOW = 256;
    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PRICE_W = 32;
    localparam int TOTAL_W = PRICE_W + SLOT_W;
    localparam int WIN_W = 9;
    localparam int ADDR_W = 1;
    localparam logic [ADDR_W-1:0] ADDR_WINDOW = 1'b0;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [CNT_W-1:0]   held;
        logic [TOTAL_W-1:0] total;
    } job_t;
endpackage

// ----- rtl/mast_front.sv -----
module mast_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mast_pkg::PRICE_W-1:0]  price,
    input  logic                          restart,
    input  logic [mast_pkg::CNT_W-1:0]    win_len,
    output logic                          job_valid,
    input  logic                          job_ready,
    output mast_pkg::job_t                job
);
    import mast_pkg::*;

    logic [PRICE_W-1:0] ring_mem [MAX_WINDOW];
    logic [SLOT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]   held_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [PRICE_W-1:0] old_reg;
    logic               full_reg;
    logic               busy_reg;
    logic               rd_reg;
    logic [CNT_W-1:0]   slot_inc;

    assign in_ready = !busy_reg;
    assign slot_inc = {1'b0, slot_reg} + 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            old_reg <= ring_mem[slot_reg];
            ring_mem[slot_reg] <= price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            held_reg  <= '0;
            total_reg <= '0;
            busy_reg  <= 1'b0;
            rd_reg    <= 1'b0;
            full_reg  <= 1'b0;
            price_reg <= '0;
        end
        else if (restart)
        begin
            slot_reg  <= '0;
            held_reg  <= '0;
            total_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            price_reg <= price;
            full_reg  <= (held_reg >= win_len);
            busy_reg  <= 1'b1;
            rd_reg    <= 1'b1;
            slot_reg  <= (slot_inc >= win_len) ? '0 : slot_inc[SLOT_W-1:0];
            if (held_reg < win_len)
                held_reg <= held_reg + 1'b1;
        end
        else if (rd_reg)
        begin
            rd_reg <= 1'b0;
            if (full_reg)
                total_reg <= total_reg - TOTAL_W'(old_reg) + TOTAL_W'(price_reg);
            else
                total_reg <= total_reg + TOTAL_W'(price_reg);
        end
        else if (busy_reg && job_ready)
            busy_reg <= 1'b0;
    end

    assign job_valid   = busy_reg && !rd_reg;
    assign job.price   = price_reg;
    assign job.held    = held_reg;
    assign job.total   = total_reg;
endmodule

// ----- rtl/mast_queue.sv -----
module mast_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  mast_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output mast_pkg::job_t rd_data
);
    import mast_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    job_t            q_mem [QDEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [PW:0]     cnt_reg;
    logic            push;
    logic            pop;

    assign wr_ready = (cnt_reg < (PW+1)'(QDEPTH));
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = q_mem[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
        end
    end
endmodule

// ----- rtl/mast_back.sv -----
module mast_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  mast_pkg::job_t                job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mast_pkg::PRICE_W-1:0]  mean_out,
    output logic [mast_pkg::PRICE_W-1:0]  current_ask,
    output logic [mast_pkg::PRICE_W-1:0]  current_bid,
    output logic [mast_pkg::PRICE_W-1:0]  earlier_ask,
    output logic [mast_pkg::PRICE_W-1:0]  earlier_bid
);
    import mast_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPD, S_OUT} state_t;
    localparam int STEP_W = $clog2(TOTAL_W + 1);

    state_t              state_reg;
    logic [TOTAL_W-1:0]  quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PRICE_W-1:0]  p_reg;
    logic [PRICE_W-1:0]  ask_reg;
    logic [PRICE_W-1:0]  bid_reg;
    logic [PRICE_W-1:0]  prev_ask_reg;
    logic [PRICE_W-1:0]  prev_bid_reg;
    logic [PRICE_W-1:0]  mean_reg;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;

    assign trial = {rem_reg, quo_reg[TOTAL_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign mean_out    = mean_reg;
    assign current_ask = ask_reg;
    assign current_bid = bid_reg;
    assign earlier_ask = prev_ask_reg;
    assign earlier_bid = prev_bid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ask_reg      <= '0;
            bid_reg      <= '0;
            prev_ask_reg <= '0;
            prev_bid_reg <= '0;
            step_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        quo_reg   <= job.total;
                        rem_reg   <= '0;
                        div_reg   <= job.held;
                        p_reg     <= job.price;
                        step_reg  <= STEP_W'(TOTAL_W);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!diff[CNT_W])
                    begin
                        rem_reg <= diff[CNT_W-1:0];
                        quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[CNT_W-1:0];
                        quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1))
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    mean_reg <= quo_reg[PRICE_W-1:0];
                    if (p_reg > quo_reg[PRICE_W-1:0])
                    begin
                        if (p_reg != prev_bid_reg && p_reg != bid_reg)
                        begin
                            prev_ask_reg <= ask_reg;
                            ask_reg      <= p_reg;
                        end
                    end
                    else if (p_reg < quo_reg[PRICE_W-1:0])
                    begin
                        if (p_reg != prev_ask_reg && p_reg != ask_reg)
                        begin
                            prev_bid_reg <= bid_reg;
                            bid_reg      <= p_reg;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> step_reg != '0)
        else $error("divider step count underflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean_reg))
        else $error("result changed while stalled");
    a_divnz: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_reg != '0)
        else $error("zero divisor");
endmodule

// ----- rtl/moving_average_spread_tracker.sv -----
// Path from input transfer to result valid with the back end idle: ring read,
// queue hand-off, back end pickup, 40-step serial divider, update.
// The serial divider limits the item rate; the front end takes the next price
// while the back end divides, as long as the queue has room.
// Reset: rst_n async low; window length 256, window empty, all levels 0.
module moving_average_spread_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] price,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] mean_out,
    output logic [31:0] current_ask,
    output logic [31:0] current_bid,
    output logic [31:0] earlier_ask,
    output logic [31:0] earlier_bid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mast_pkg::ADDR_W+1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mast_pkg::*;

    logic [CNT_W-1:0] win_reg;
    logic [CNT_W-1:0] win_next;
    logic             wr_en;
    logic             restart;
    logic             f_valid;
    logic             f_ready;
    job_t             f_job;
    logic             b_valid;
    logic             b_ready;
    job_t             b_job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign restart = wr_en && (paddr[ADDR_W+1:2] == ADDR_WINDOW);
    assign prdata  = (paddr[ADDR_W+1:2] == ADDR_WINDOW) ? 32'(win_reg) : '0;

    always_comb
    begin
        win_next = pwdata[CNT_W-1:0];
        if (pwdata[WIN_W-1:0] == '0)
            win_next = CNT_W'(1);
        else if (32'(pwdata[WIN_W-1:0]) > 32'(MAX_WINDOW))
            win_next = CNT_W'(MAX_WINDOW);
        else
            win_next = CNT_W'(pwdata[WIN_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= CNT_W'(MAX_WINDOW);
        else if (restart)
            win_reg <= win_next;
    end

    mast_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .price(price), .restart(restart), .win_len(win_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    mast_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_data(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
    );

    mast_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(b_valid), .job_ready(b_ready),
        .job(b_job), .out_valid(out_valid), .out_ready(out_ready),
        .mean_out(mean_out), .current_ask(current_ask), .current_bid(current_bid),
        .earlier_ask(earlier_ask), .earlier_bid(earlier_bid)
    );
endmodule

// ----- tb/mast_checker.sv -----
`timescale 1ns / 1ps

module mast_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] price,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] mean_out,
    input  logic [31:0] current_ask,
    input  logic [31:0] current_bid,
    input  logic [31:0] earlier_ask,
    input  logic [31:0] earlier_bid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mast_pkg::ADDR_W+1:0] paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    import mast_pkg::*;

    typedef struct packed {
        logic [31:0] mean;
        logic [31:0] ask;
        logic [31:0] bid;
        logic [31:0] pask;
        logic [31:0] pbid;
    } quote_t;

    logic [31:0] ring [MAX_WINDOW];
    int unsigned slot_q;
    int unsigned held_q;
    logic [63:0] total_q;
    logic [31:0] ask_q, bid_q, pask_q, pbid_q;
    int unsigned win_q;
    quote_t quotes_due[$];

    assign pending = quotes_due.size();

    function automatic int unsigned clamp_window(logic [31:0] v);
        int unsigned w;
        w = v & 32'h1FF;
        if (w == 0) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        return w;
    endfunction

    task automatic track_price(logic [31:0] p);
        int unsigned s;
        logic [31:0] m;
        quote_t q;
        s = slot_q % win_q;
        if (held_q < win_q)
        begin
            total_q += p;
            held_q++;
        end
        else
            total_q = total_q - ring[s] + p;
        ring[s] = p;
        slot_q = (s + 1) % win_q;
        m = 32'(total_q / held_q);
        if (p > m)
        begin
            if (p != pbid_q && p != bid_q)
            begin
                pask_q = ask_q;
                ask_q = p;
            end
        end
        else if (p < m)
        begin
            if (p != pask_q && p != ask_q)
            begin
                pbid_q = bid_q;
                bid_q = p;
            end
        end
        q.mean = m;
        q.ask = ask_q;
        q.bid = bid_q;
        q.pask = pask_q;
        q.pbid = pbid_q;
        quotes_due.push_back(q);
    endtask

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $error("%s expected %0d got %0d", name, e, a);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        slot_q = 0;
        held_q = 0;
        total_q = 0;
        ask_q = 0;
        bid_q = 0;
        pask_q = 0;
        pbid_q = 0;
        win_q = MAX_WINDOW;
    end

    always @(posedge clk)
    begin
        quote_t q;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr[ADDR_W+1:2] == ADDR_WINDOW)
            begin
                win_q = clamp_window(pwdata);
                slot_q = 0;
                held_q = 0;
                total_q = 0;
            end
            if (in_valid && in_ready)
                track_price(price);
            if (out_valid && out_ready)
            begin
                if (quotes_due.size() == 0)
                begin
                    $error("unexpected result");
                    fail_count++;
                end
                else
                begin
                    q = quotes_due.pop_front();
                    check_field("mean_out", q.mean, mean_out);
                    check_field("current_ask", q.ask, current_ask);
                    check_field("current_bid", q.bid, current_bid);
                    check_field("earlier_ask", q.pask, earlier_ask);
                    check_field("earlier_bid", q.pbid, earlier_bid);
                end
            end
        end
    end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mast_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] price;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] mean_out, current_ask, current_bid, earlier_ask, earlier_bid;
    logic        psel, penable, pwrite;
    logic [ADDR_W+1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          calm;
    bit          sink_stall;

    moving_average_spread_tracker uut (.*);
    mast_checker chk (.*);

    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    // result side stall bursts
    always @(posedge clk)
    begin
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
            out_ready <= 1;
        end
        else
            out_ready <= 1;
    end

    task automatic send_price(logic [31:0] p);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1;
        price <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_window(logic [31:0] w);
        drain();
        psel <= 1;
        pwrite <= 1;
        paddr <= {ADDR_WINDOW, 2'b00};
        pwdata <= w;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_price(int unsigned base);
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            2: return $urandom_range(0, 3);
            default: return base + $urandom_range(0, 40) - 20;
        endcase
    endfunction

    initial
    begin
        int unsigned base;
        int unsigned wins [6] = '{1, 2, 3, 7, 16, 256};
        rst_n = 0;
        in_valid = 0;
        price = 0;
        out_ready = 1;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        calm = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_price(32'hFFFF_FFFF);
        send_price(32'hFFFF_FFFF);
        send_price(0);
        send_price(32'h8000_0000);
        send_price(100);
        send_price(100);
        send_price(32'hFFFF_FFFF);
        set_window(0);
        send_price(5);
        send_price(9);
        set_window(2);
        send_price(10);
        send_price(20);
        send_price(30);
        send_price(20);
        send_price(10);
        set_window(9'h1FF);
        send_price(0);
        send_price(32'hFFFF_FFFF);
        set_window(3);
        send_price(50);
        send_price(60);
        send_price(50);
        send_price(40);
        send_price(60);

        for (int ph = 0; ph < 12; ph++)
        begin
            set_window(ph < 6 ? wins[ph] : $urandom_range(1, 300) | ($urandom_range(0, 1) << 8));
            base = $urandom();
            if (ph == 11)
                calm = 1;
            for (int i = 0; i < 50; i++)
            begin
                send_price(rand_price(base));
                if (i == 25)
                    drain();
            end
        end

        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
